FILE: hdl/scfh_pkg.sv
`timescale 1ns / 1ps
// Package for segment_circle_first_hit: widths, status codes and pipeline stage types.
// No dependencies.
package scfh_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int TAU_FRAC_BITS = 16;

   localparam int RAD_W   = COORD_WIDTH - 1;      // radius
   localparam int DIFF_W  = COORD_WIDTH + 1;      // coordinate differences
   localparam int PROD_W  = 2 * DIFF_W;           // products of differences
   localparam int SUM_W   = PROD_W + 1;           // signed b and c
   localparam int MAG_W   = PROD_W;               // a, |b|, square root
   localparam int D_W     = 2 * MAG_W;            // discriminant
   localparam int REM_W   = MAG_W + 2;            // square root remainder
   localparam int DR_W    = MAG_W + 1;            // divider remainder
   localparam int Q_W     = TAU_FRAC_BITS + 1;    // tau
   localparam int SQ_STEPS = MAG_W;

   localparam int REQ_W = 8 * ((6 * COORD_WIDTH + RAD_W + 7) / 8);
   localparam int RSP_W = 8 * ((1 + Q_W + 3 + 7) / 8);

   typedef enum logic [2:0] {
      ST_INSIDE = 3'd0,
      ST_ENTRY  = 3'd1,
      ST_AWAY   = 3'd2,
      ST_ZERO   = 3'd3,
      ST_NONE   = 3'd4,
      ST_BEYOND = 3'd5
   } status_type;

   typedef struct packed {
      status_type       status;
      logic             done;
      logic [MAG_W-1:0] bm;
      logic [MAG_W-1:0] a;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] root;
      logic [D_W-1:0]   dsh;
   } sq_type;

   typedef struct packed {
      status_type       status;
      logic [MAG_W-1:0] a;
      logic [DR_W-1:0]  r;
      logic [Q_W-1:0]   q;
   } dv_type;

endpackage

FILE: hdl/segment_circle_first_hit.sv
`timescale 1ns / 1ps
// Segment/circle first entry: fully pipelined, one item per cycle while the output moves.
// Depends on scfh_pkg (widths, status codes, stage types).
//
//  channel | dir | width | fields (low bit up)
//  req     | in  | 112   | start_x, start_y, end_x, end_y, center_x, center_y, radius
//  rsp     | out | 24    | hit, tau, status
//
// A result passes through 58 register stages after its item is accepted.
// One item enters per cycle while the output moves.
// Depth is set by the bit-per-stage square root (34 stages) and divider (17).
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output register freezes every stage; bubbles are not squeezed out.
module segment_circle_first_hit
   import scfh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, tau, status, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   logic adv;

   logic signed [COORD_WIDTH-1:0] in_sx, in_sy, in_ex, in_ey, in_cx, in_cy;
   logic [RAD_W-1:0] in_r;

   // stage 1: differences
   logic s1_v_ff;
   logic signed [DIFF_W-1:0] s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff;
   logic signed [DIFF_W-1:0] s1_ux_in, s1_uy_in, s1_vx_in, s1_vy_in;
   logic [RAD_W-1:0] s1_r_ff;
   // stage 2: products
   logic s2_v_ff;
   logic signed [PROD_W-1:0] s2_uxx_ff, s2_uyy_ff, s2_uxvx_ff, s2_uyvy_ff, s2_vxx_ff, s2_vyy_ff;
   logic [2*RAD_W-1:0] s2_rr_ff;
   // stage 3: c, b, a
   logic s3_v_ff;
   logic signed [SUM_W-1:0] s3_c_ff, s3_b_ff, s3_c_in, s3_b_in;
   logic [MAG_W-1:0] s3_a_ff, s3_a_in;
   // stage 4: b*b, a*c, early decisions
   logic s4_v_ff;
   logic [MAG_W-1:0] s4_bm_ff, s4_a_ff, s4_bm_in, s4_cu;
   logic [D_W-1:0] s4_bb_ff, s4_ac_ff, s4_bb_in, s4_ac_in;
   status_type s4_st_ff, s4_st_in;
   logic s4_done_ff, s4_done_in;
   // square root stages; entry 0 holds the discriminant
   logic [SQ_STEPS:0] sq_v_ff;
   sq_type sq_ff [0:SQ_STEPS];
   sq_type sq_head_in;
   logic [D_W:0] s5_diff;
   // divider stages; entry 0 holds the numerator
   logic [Q_W:0] dv_v_ff;
   dv_type dv_ff [0:Q_W];
   dv_type dv_head_in;
   logic [MAG_W:0] fin_lim;
   logic fin_beyond;
   // output register
   logic out_v_ff;
   logic out_hit_ff;
   logic [Q_W-1:0] out_tau_ff;
   status_type out_st_ff;

   assign adv = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      in_sx = req_tdata[0*COORD_WIDTH +: COORD_WIDTH];
      in_sy = req_tdata[1*COORD_WIDTH +: COORD_WIDTH];
      in_ex = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
      in_ey = req_tdata[3*COORD_WIDTH +: COORD_WIDTH];
      in_cx = req_tdata[4*COORD_WIDTH +: COORD_WIDTH];
      in_cy = req_tdata[5*COORD_WIDTH +: COORD_WIDTH];
      in_r  = req_tdata[6*COORD_WIDTH +: RAD_W];
      s1_ux_in = DIFF_W'(in_sx) - DIFF_W'(in_cx);
      s1_uy_in = DIFF_W'(in_sy) - DIFF_W'(in_cy);
      s1_vx_in = DIFF_W'(in_ex) - DIFF_W'(in_sx);
      s1_vy_in = DIFF_W'(in_ey) - DIFF_W'(in_sy);
   end

   always_comb begin
      s3_c_in = SUM_W'(s2_uxx_ff) + SUM_W'(s2_uyy_ff) - SUM_W'(s2_rr_ff);
      s3_b_in = SUM_W'(s2_uxvx_ff) + SUM_W'(s2_uyvy_ff);
      s3_a_in = MAG_W'(s2_vxx_ff) + MAG_W'(s2_vyy_ff);
   end

   always_comb begin
      s4_bm_in = MAG_W'(-s3_b_ff);
      s4_cu    = MAG_W'(s3_c_ff);
      s4_bb_in = D_W'(s4_bm_in) * D_W'(s4_bm_in);
      s4_ac_in = D_W'(s3_a_ff) * D_W'(s4_cu);
      s4_done_in = 1'b1;
      priority if (s3_c_ff[SUM_W-1] || s3_c_ff == '0) begin
         s4_st_in = ST_INSIDE;
      end else if (!s3_b_ff[SUM_W-1] && s3_b_ff != '0) begin
         s4_st_in = ST_AWAY;
      end else if (s3_a_ff == '0) begin
         s4_st_in = ST_ZERO;
      end else begin
         s4_st_in   = ST_ENTRY;
         s4_done_in = 1'b0;
      end
   end

   always_comb begin
      s5_diff = {1'b0, s4_bb_ff} - {1'b0, s4_ac_ff};
      sq_head_in.status = s4_st_ff;
      sq_head_in.done   = s4_done_ff;
      sq_head_in.bm     = s4_bm_ff;
      sq_head_in.a      = s4_a_ff;
      sq_head_in.rem    = '0;
      sq_head_in.root   = '0;
      sq_head_in.dsh    = s5_diff[D_W-1:0];
      // negative discriminant
      if (!s4_done_ff && s5_diff[D_W]) begin
         sq_head_in.status = ST_NONE;
         sq_head_in.done   = 1'b1;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      sq_type nxt;
      logic [REM_W-1:0] shr;
      logic [REM_W-1:0] trial;
      logic ge;
      always_comb begin
         nxt   = sq_ff[k];
         shr   = {sq_ff[k].rem[REM_W-3:0], sq_ff[k].dsh[D_W-1 -: 2]};
         trial = {sq_ff[k].root, 2'b01};
         ge    = shr >= trial;
         nxt.rem  = ge ? shr - trial : shr;
         nxt.root = {sq_ff[k].root[MAG_W-2:0], ge};
         nxt.dsh  = {sq_ff[k].dsh[D_W-3:0], 2'b00};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= nxt;
         end
      end
   end

   // entry lies past the end iff |b| - a exceeds floor(sqrt(D))
   always_comb begin
      fin_lim    = {1'b0, sq_ff[SQ_STEPS].a} + {1'b0, sq_ff[SQ_STEPS].root};
      fin_beyond = {1'b0, sq_ff[SQ_STEPS].bm} > fin_lim;
      dv_head_in.status = sq_ff[SQ_STEPS].status;
      dv_head_in.a      = sq_ff[SQ_STEPS].a;
      dv_head_in.q      = '0;
      dv_head_in.r      = DR_W'(sq_ff[SQ_STEPS].bm - sq_ff[SQ_STEPS].root
                                - MAG_W'(sq_ff[SQ_STEPS].rem != '0));
      if (!sq_ff[SQ_STEPS].done) begin
         dv_head_in.status = fin_beyond ? ST_BEYOND : ST_ENTRY;
      end
   end

   // one quotient bit per stage, integer bit first
   for (genvar j = 0; j < Q_W; j++) begin : g_dv
      dv_type nxt;
      logic [DR_W-1:0] t;
      logic ge;
      always_comb begin
         nxt = dv_ff[j];
         if (j == 0) begin
            t = dv_ff[j].r;
         end else begin
            t = {dv_ff[j].r[DR_W-2:0], 1'b0};
         end
         ge    = t >= DR_W'(dv_ff[j].a);
         nxt.r = ge ? t - DR_W'(dv_ff[j].a) : t;
         nxt.q = {dv_ff[j].q[Q_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j+1] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         sq_v_ff  <= '0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_tvalid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         sq_v_ff  <= {sq_v_ff[SQ_STEPS-1:0], s4_v_ff};
         dv_v_ff  <= {dv_v_ff[Q_W-1:0], sq_v_ff[SQ_STEPS]};
         out_v_ff <= dv_v_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ux_ff <= s1_ux_in;
         s1_uy_ff <= s1_uy_in;
         s1_vx_ff <= s1_vx_in;
         s1_vy_ff <= s1_vy_in;
         s1_r_ff  <= in_r;
         s2_uxx_ff  <= s1_ux_ff * s1_ux_ff;
         s2_uyy_ff  <= s1_uy_ff * s1_uy_ff;
         s2_uxvx_ff <= s1_ux_ff * s1_vx_ff;
         s2_uyvy_ff <= s1_uy_ff * s1_vy_ff;
         s2_vxx_ff  <= s1_vx_ff * s1_vx_ff;
         s2_vyy_ff  <= s1_vy_ff * s1_vy_ff;
         s2_rr_ff   <= (2*RAD_W)'(s1_r_ff) * (2*RAD_W)'(s1_r_ff);
         s3_c_ff <= s3_c_in;
         s3_b_ff <= s3_b_in;
         s3_a_ff <= s3_a_in;
         s4_bm_ff   <= s4_bm_in;
         s4_a_ff    <= s3_a_ff;
         s4_bb_ff   <= s4_bb_in;
         s4_ac_ff   <= s4_ac_in;
         s4_st_ff   <= s4_st_in;
         s4_done_ff <= s4_done_in;
         sq_ff[0] <= sq_head_in;
         dv_ff[0] <= dv_head_in;
         out_st_ff  <= dv_ff[Q_W].status;
         out_hit_ff <= dv_ff[Q_W].status == ST_INSIDE || dv_ff[Q_W].status == ST_ENTRY;
         out_tau_ff <= (dv_ff[Q_W].status == ST_ENTRY) ? dv_ff[Q_W].q : '0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {(RSP_W - Q_W - 4)'(0), out_st_ff, out_tau_ff, out_hit_ff};

   // a hit is reported exactly for the two hitting statuses
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_hit_ff == (out_st_ff == ST_INSIDE || out_st_ff == ST_ENTRY)))
      else $error("hit flag disagrees with status");

   // tau never passes the end point
   a_tau_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> out_tau_ff <= Q_W'(1 << TAU_FRAC_BITS))
      else $error("tau beyond end point");

   // final root remainder stays within 2*root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[SQ_STEPS] |-> sq_ff[SQ_STEPS].rem <= {1'b0, sq_ff[SQ_STEPS].root, 1'b0})
      else $error("square root remainder out of range");

   // a stall freezes the divider head
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_v_ff) && $stable(dv_ff[0].r))
      else $error("pipeline moved during stall");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for segment_circle_first_hit: random and directed segment/circle queries,
// expected hit/tau/status computed in exact integer arithmetic. Depends on scfh_pkg.
module testbench;
   import scfh_pkg::*;

   typedef struct packed {
      logic [14:0] radius;
      logic [15:0] cy, cx, ey, ex, sy, sx;
   } query_type;

   typedef struct packed {
      status_type  status;
      logic [16:0] tau;
      logic        hit;
   } answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   query_type  pending_queries[$];
   answer_type expected_answers[$];
   int      errors = 0;
   int      req_gap = 0, rsp_gap = 0;
   bit      stim_done = 1'b0;
   bit      req_stall = 1'b0;
   longint  cycles = 0;

   segment_circle_first_hit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [127:0] isqrt_ceil(logic [127:0] d);
      logic [127:0] r, cand;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         cand = r | (128'd1 << i);
         if (cand * cand <= d) r = cand;
      end
      if (r * r != d) r = r + 1;
      return r;
   endfunction

   function automatic answer_type first_hit(query_type q);
      answer_type   ans;
      longint       ux, uy, vx, vy, c, b, rr;
      logic [127:0] a, bm, d, s, num;
      ux = longint'($signed(q.sx)) - longint'($signed(q.cx));
      uy = longint'($signed(q.sy)) - longint'($signed(q.cy));
      vx = longint'($signed(q.ex)) - longint'($signed(q.sx));
      vy = longint'($signed(q.ey)) - longint'($signed(q.sy));
      rr = longint'(q.radius);
      c = ux * ux + uy * uy - rr * rr;
      ans = '0;
      if (c <= 0) begin
         ans.hit = 1'b1;
         ans.status = ST_INSIDE;
         return ans;
      end
      b = ux * vx + uy * vy;
      if (b > 0) begin
         ans.status = ST_AWAY;
         return ans;
      end
      a = 128'(vx * vx + vy * vy);
      if (a == 0) begin
         ans.status = ST_ZERO;
         return ans;
      end
      bm = 128'(-b);
      if (bm * bm < a * 128'(c)) begin
         ans.status = ST_NONE;
         return ans;
      end
      d = bm * bm - a * 128'(c);
      if (bm > a && (bm - a) * (bm - a) > d) begin
         ans.status = ST_BEYOND;
         return ans;
      end
      s = isqrt_ceil(d);
      num = (bm - s) << TAU_FRAC_BITS;
      ans.tau = 17'(num / a);
      ans.hit = 1'b1;
      ans.status = ST_ENTRY;
      return ans;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] near(logic [15:0] base, int span);
      return base + 16'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic add_query(input int sx, sy, ex, ey, cx, cy, r);
      query_type q;
      q.sx = 16'(sx); q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
      q.cx = 16'(cx); q.cy = 16'(cy); q.radius = 15'(r);
      pending_queries.push_back(q);
   endtask

   initial begin
      query_type q;
      int     kind, span;
      // start inside, on circle, tangent, entry, away, zero length, miss, beyond end
      add_query(0, 0, 100, 0, 0, 0, 10);
      add_query(10, 0, 100, 0, 0, 0, 10);
      add_query(-20, 10, 20, 10, 0, 0, 10);
      add_query(-20, 0, 20, 0, 0, 0, 10);
      add_query(-20, 0, 20, 0, 0, 0, 0);
      add_query(20, 0, 40, 0, 0, 0, 10);
      add_query(20, 0, 20, 0, 0, 0, 10);
      add_query(-20, 50, 20, 50, 0, 0, 10);
      add_query(-20, 0, -15, 0, 0, 0, 10);
      add_query(-20, 0, -10, 0, 0, 0, 10);
      add_query(32'h8000, 32'h8000, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff);
      add_query(32'h8000, 32'h8000, 32'h7fff, 32'h7fff, 0, 0, 1);
      add_query(32'h7fff, 32'h7fff, 32'h8000, 32'h8000, 32'h8000, 32'h7fff, 32'h7fff);
      add_query(32'h8000, 32'h7fff, 32'h7fff, 32'h8000, 0, 0, 32'h7fff);
      add_query(32'h8000, 0, 32'h7fff, 0, 32'h7fff, 0, 0);
      add_query(32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'h7fff);
      add_query(32'h8000, 32'h8000, 32'h8000, 32'h8001, 32'h7fff, 32'h7fff, 0);
      for (int n = 0; n < 600; n++) begin
         kind = $urandom_range(0, 9);
         q = query_type'(111'({$urandom, $urandom, $urandom, $urandom}));
         if (kind < 7) begin
            // mostly segments aimed near the circle so every status shows up
            span = (kind < 3) ? 300 : 32767;
            q.radius = 15'($urandom_range(0, (kind < 3) ? 200 : 32767));
            q.sx = near(q.cx, span); q.sy = near(q.cy, span);
            q.ex = near(q.cx, span); q.ey = near(q.cy, span);
         end
         pending_queries.push_back(q);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // driver: present items at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_stall) begin
            // hold item
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_queries.size() > 0) begin
            req_tdata <= REQ_W'(pending_queries.pop_front());
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      answer_type got, want;
      cycles <= cycles + 1;
      req_stall <= req_tvalid && !req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_answers.push_back(first_hit(query_type'(req_tdata[110:0])));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = answer_type'(rsp_tdata[20:0]);
         if (expected_answers.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected response %h", got);
         end else begin
            want = expected_answers.pop_front();
            if (got.hit !== want.hit || got.tau !== want.tau ||
                got.status !== want.status) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch: expected hit %0d tau %0d status %0d, got %0d %0d %0d",
                           want.hit, want.tau, want.status,
                           got.hit, got.tau, got.status);
            end
         end
      end
   end

   initial begin
      wait (stim_done && expected_answers.size() == 0);
      repeat (120) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      wait (cycles > 200000);
      $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: files.f
hdl/scfh_pkg.sv
hdl/segment_circle_first_hit.sv
tb/testbench.sv
